>>> src/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants of the priority ordered slot list
// Entry and wave records passed along the cell row, operation and status codes.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int SLOTS  = 32;
	localparam int SLOT_W = 5;
	localparam int PRIO_W = 8;

	// operation codes of the kind field
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PRESENT   = 2'd2
	} status_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_WALK
	} ctl_state_t;

	// one list position held by a cell
	typedef struct packed {
		logic                     valid;
		logic [SLOT_W-1:0]        slot;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// operation travelling down the row, one cell per cycle
	typedef struct packed {
		logic   valid;
		logic   kind;
		logic   flag;   // insert: now shifting down; remove: target already passed
		entry_t carry;  // insert: entry being pushed down; remove: target slot
	} wave_t;

	localparam entry_t ENTRY_NONE = '{valid: 1'b0, slot: '0, prio: '0};

endpackage

>>> src/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell: one position of the sorted slot list
// Holds one entry and applies the passing insert or remove wave, then hands
// the wave on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module pol_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  pol_pkg::wave_t  wave_i,
	input  pol_pkg::entry_t next_i,
	output pol_pkg::entry_t entry_o,
	output pol_pkg::wave_t  wave_o
);
	import pol_pkg::*;

	logic                     valid_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic                     wave_valid_q;
	logic                     wave_kind_q;
	logic                     wave_flag_q;
	entry_t                   wave_carry_q;

	entry_t entry_cur;
	entry_t entry_d;
	wave_t  wave_d;
	logic   take;
	logic   hit;

	assign entry_cur = '{valid: valid_q, slot: slot_q, prio: prio_q};

	// apply the wave to this position
	always_comb begin
		entry_d = entry_cur;
		wave_d  = wave_i;
		take    = 1'b0;
		hit     = 1'b0;
		if (wave_i.valid) begin
			if (wave_i.kind == KIND_INSERT) begin
				// new entry goes before the first strictly lower priority
				take = wave_i.flag || !valid_q || (prio_q < wave_i.carry.prio);
				if (take) begin
					entry_d      = wave_i.carry;
					wave_d.carry = entry_cur;
					wave_d.flag  = 1'b1;
				end
			end else begin
				// from the matching position on, pull the neighbor up
				hit         = valid_q && (slot_q == wave_i.carry.slot);
				wave_d.flag = wave_i.flag || hit;
				if (wave_d.flag) begin
					entry_d = next_i;
				end
			end
		end
	end

	// control bits of the entry and the wave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			wave_valid_q <= 1'b0;
		end else begin
			valid_q      <= entry_d.valid;
			wave_valid_q <= wave_d.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		slot_q       <= entry_d.slot;
		prio_q       <= entry_d.prio;
		wave_kind_q  <= wave_d.kind;
		wave_flag_q  <= wave_d.flag;
		wave_carry_q <= wave_d.carry;
	end

	assign entry_o = entry_cur;
	assign wave_o  = '{valid: wave_valid_q, kind: wave_kind_q, flag: wave_flag_q,
		carry: wave_carry_q};

endmodule

>>> src/priority_ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// priority_ordered_list_insert_remove: slot list sorted by signed priority
// A row of cells holds the list in descending priority, head in cell 0.
// Insert and remove travel down the row as a wave, one cell per cycle.
// ----------------------------------------------------------------------------
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+-------------------------
//  command  | kind, slot, priority_req             | start high, busy low
//  result   | status, head_slot, list_empty        | done strobe, one cycle
//
// An operation that links or unlinks raises the done strobe, registered from
// its wave leaving the row: the wave walks all 32 cells, one per cycle.
// A refused insert or a remove of an absent slot answers in the next cycle.
// busy stays high while a wave is in the row. Reset empties the list; the
// result side cannot stall, so done is a plain one-cycle strobe.
module priority_ordered_list_insert_remove (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               kind,
	input  logic [pol_pkg::SLOT_W-1:0]         slot,
	input  logic signed [pol_pkg::PRIO_W-1:0]  priority_req,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [pol_pkg::SLOT_W-1:0]         head_slot,
	output logic                               list_empty
);
	import pol_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	logic [SLOTS-1:0]  linked_q;
	logic              done_q;
	status_t           status_q;
	logic [SLOT_W-1:0] head_q;
	logic              empty_q;

	entry_t cell_entry [SLOTS];
	wave_t  wave_chain [SLOTS+1];

	logic accept;
	logic present;
	logic launch;
	logic wave_end;

	assign accept   = start && !busy;
	assign present  = linked_q[slot];
	assign launch   = accept && ((kind == KIND_INSERT) ? !present : present);
	assign wave_end = wave_chain[SLOTS].valid;

	// new wave into the head of the row
	assign wave_chain[0] = '{valid: launch, kind: kind, flag: 1'b0,
		carry: '{valid: 1'b1, slot: slot, prio: priority_req}};

	// row of cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		entry_t next_entry;
		if (i < SLOTS-1) begin : g_mid
			assign next_entry = cell_entry[i+1];
		end else begin : g_last
			assign next_entry = ENTRY_NONE;
		end
		pol_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wave_i  (wave_chain[i]),
			.next_i  (next_entry),
			.entry_o (cell_entry[i]),
			.wave_o  (wave_chain[i+1])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: if (launch) state_d = CTL_WALK;
			CTL_WALK: if (wave_end) state_d = CTL_IDLE;
			default:  state_d = CTL_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		unique case (state_q)
			CTL_IDLE: busy = 1'b0;
			CTL_WALK: busy = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// membership bits follow every accepted link or unlink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q <= '0;
		end else if (launch) begin
			linked_q[slot] <= (kind == KIND_INSERT);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= wave_end || (accept && !launch);
		end
	end

	// result payload, head read from cell 0
	always_ff @(posedge clk) begin
		if (wave_end) begin
			status_q <= ST_DONE;
		end else if (kind == KIND_INSERT) begin
			status_q <= ST_PRESENT;
		end else begin
			status_q <= ST_NOT_FOUND;
		end
		head_q  <= cell_entry[0].valid ? cell_entry[0].slot : '0;
		empty_q <= !cell_entry[0].valid;
	end

	assign done       = done_q;
	assign status     = status_q;
	assign head_slot  = head_q;
	assign list_empty = empty_q;

endmodule
